// ----- sv/ptpg_pkg.sv -----
// shared constants, types and region codes for the terrain pixel generator
// no dependencies; every other file takes names from here by scope
package ptpg_pkg;

	// pipeline depth from input register to output register
	localparam int unsigned NUM_STG = 15;

	// hash multipliers
	localparam logic [31:0] HASH_MUL_X = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
	localparam logic [31:0] HASH_MUL_F = 32'd1274126177;
	localparam int unsigned HASH_SHR_A = 13;
	localparam int unsigned HASH_SHR_B = 16;

	// pattern geometry
	localparam int unsigned STRIPE_PERIOD = 96;
	localparam int unsigned STRIPE_HALF   = 48;
	localparam int          STRIPE_LO     = -40;
	localparam int          STRIPE_HI     = -35;
	localparam int unsigned CELL_W        = 53;
	localparam int unsigned CELL_H        = 41;
	localparam int unsigned JIT_X         = 29;
	localparam int unsigned JIT_Y         = 25;
	localparam int unsigned OFS_X         = 12;
	localparam int unsigned OFS_Y         = 8;
	localparam int unsigned CORE_R2       = 64;
	localparam int unsigned RIM_R2        = 81;
	localparam int unsigned DIAG_MOD      = 23;
	localparam logic [8:0]  SPECK_VAL     = 9'd7;
	localparam int unsigned JIT_Y_SHR     = 8;

	localparam int unsigned RX_W = $clog2(CELL_W);
	localparam int unsigned RY_W = $clog2(CELL_H);
	localparam int unsigned SHADE_W = 5;

	typedef enum logic [2:0] {
		REG_STRIPE     = 3'd0,
		REG_CORE       = 3'd1,
		REG_RIM        = 3'd2,
		REG_SPECK      = 3'd3,
		REG_DIAG       = 3'd4,
		REG_BACKGROUND = 3'd5
	} region_t;

	// colours
	localparam logic [7:0] STRIPE_R = 8'd40,  STRIPE_G = 8'd78,  STRIPE_B = 8'd98;
	localparam logic [7:0] CORE_R   = 8'd88,  CORE_G   = 8'd62,  CORE_B   = 8'd50;
	localparam logic [7:0] RIM_R    = 8'd110, RIM_G    = 8'd80,  RIM_B    = 8'd62;
	localparam logic [7:0] SPECK_R  = 8'd210, SPECK_G  = 8'd200, SPECK_B  = 8'd170;
	localparam logic [7:0] DIAG_R   = 8'd38,  DIAG_G   = 8'd36,  DIAG_B   = 8'd48;
	localparam logic [7:0] BG_R     = 8'd18,  BG_G     = 8'd24,  BG_B     = 8'd34;

	// per-pixel flags carried alongside the cell hash path
	typedef struct packed {
		logic               stripe;
		logic               speck;
		logic               diag;
		logic [SHADE_W-1:0] shade;
		logic [RX_W-1:0]    rx;
		logic [RY_W-1:0]    ry;
	} side_t;

endpackage

// ----- sv/ptpg_cdiv.sv -----
// floor division and floor modulo of a signed 33-bit value by a constant
// four register stages: offset, reciprocal multiply, back-multiply, correction; uses ptpg_pkg
module ptpg_cdiv #(
	parameter int unsigned DIVISOR = ptpg_pkg::CELL_W
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [32:0]           num,
	output logic signed [31:0]           quot,
	output logic [$clog2(DIVISOR)-1:0]   rem
);

	// divisor range 17..255: reciprocal must fit 32 bits at this shift
	localparam int unsigned REM_W = $clog2(DIVISOR);
	localparam int unsigned V_W   = 34;
	localparam int unsigned SHIFT = 36;
	localparam int unsigned Q_W   = V_W + 32 - SHIFT;
	localparam int unsigned P_W   = V_W + 32;
	localparam logic [63:0] MULT64 = (64'd1 << SHIFT) / DIVISOR;
	localparam logic [31:0] MULT   = MULT64[31:0];
	localparam logic [63:0] OFQ64  = ((64'd1 << 32) + 64'(DIVISOR) - 64'd1) / DIVISOR;
	localparam logic [63:0] OFS64  = OFQ64 * 64'(DIVISOR);
	localparam logic [V_W-1:0] OFS_Q = OFQ64[V_W-1:0];
	localparam logic [V_W-1:0] OFS_V = OFS64[V_W-1:0];
	localparam logic [V_W-1:0] D_V   = V_W'(DIVISOR);

	logic [V_W-1:0] num_ext;
	logic [V_W-1:0] v_s1, v_s2, v_s3;
	logic [P_W-1:0] prod_s2;
	logic [Q_W-1:0] q0, q0_s3;
	logic [V_W-1:0] pq, pq_s3;
	logic [V_W-1:0] r0, rfix, qfix;
	logic           corr;

	// offset makes the value non-negative without moving its residue
	assign num_ext = {{(V_W-33){num[32]}}, num};
	assign q0      = prod_s2[P_W-1:SHIFT];
	assign pq      = {{(V_W-Q_W){1'b0}}, q0} * D_V;
	assign r0      = v_s3 - pq_s3;
	assign corr    = (r0 >= D_V);
	assign rfix    = corr ? r0 - D_V : r0;
	assign qfix    = {{(V_W-Q_W){1'b0}}, q0_s3} + V_W'(corr) - OFS_Q;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= num_ext + OFS_V;
			v_s2    <= v_s1;
			prod_s2 <= P_W'(v_s1) * P_W'(MULT);
			v_s3    <= v_s2;
			q0_s3   <= q0;
			pq_s3   <= pq;
			quot    <= qfix[31:0];
			rem     <= rfix[REM_W-1:0];
		end
	end

endmodule

// ----- sv/ptpg_hash.sv -----
// 32-bit multiplicative coordinate hash, wrapping modulo 2^32
// four register stages, multiply stages alternating with xor-shift stages; uses ptpg_pkg
module ptpg_hash (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] key_x,
	input  logic [31:0] key_y,
	output logic [31:0] hash
);

	logic [31:0] px_s1, py_s1;
	logic [31:0] sum;
	logic [31:0] mix_s2;
	logic [31:0] prod_s3;

	assign sum = px_s1 + py_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= key_x * ptpg_pkg::HASH_MUL_X;
			py_s1   <= key_y * ptpg_pkg::HASH_MUL_Y;
			mix_s2  <= sum ^ (sum >> ptpg_pkg::HASH_SHR_A);
			prod_s3 <= mix_s2 * ptpg_pkg::HASH_MUL_F;
			hash    <= prod_s3 ^ (prod_s3 >> ptpg_pkg::HASH_SHR_B);
		end
	end

endmodule

// ----- sv/procedural_terrain_pixel_generator_core.sv -----
// top level of the terrain pixel generator: coordinate pair in, colour and region out
// depends on ptpg_pkg, ptpg_cdiv and ptpg_hash
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   input   | in_valid / in_ready | world_x, world_y (30b signed)
//   output  | out_valid/out_ready | red, green, blue, region
//
// one item per cycle while the output is not stalled; 15 register stages
// the depth is set by the chain pixel divide, cell hash, jitter divide, radius square
// arst_n clears the stage valid bits only; payload registers are not reset
// a stall on the output freezes every stage at once, so in_ready drops with it
// stages with no item in them are not squeezed out while stalled
module procedural_terrain_pixel_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [29:0] world_x,
	input  logic signed [29:0] world_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [2:0]         region
);

	localparam int unsigned NS = ptpg_pkg::NUM_STG;

	logic                  adv;
	logic [NS:1]           vld_s;

	logic signed [29:0]    x_s1, y_s1;
	logic signed [29:0]    y_dly_s [2:5];
	logic [31:0]           xe, ye;
	logic signed [32:0]    diag_sum;

	logic signed [31:0]    cell_x, cell_y;
	logic signed [31:0]    quot96, quot23, quot29, quot25;
	logic [6:0]            t96;
	logic [ptpg_pkg::RX_W-1:0] rx;
	logic [ptpg_pkg::RY_W-1:0] ry;
	logic [4:0]            r23;
	logic [4:0]            m29, m25;
	logic [31:0]           pix_hash, cell_hash;

	logic [6:0]            tri_v;
	logic signed [31:0]    ydiff;
	ptpg_pkg::side_t       side_st5;
	ptpg_pkg::side_t       side_s [6:14];

	logic signed [7:0]     dx, dy;
	logic signed [15:0]    sqx, sqy;
	logic [11:0]           r2_s14;

	ptpg_pkg::region_t     reg_sel;
	logic [7:0]            r_sel, g_sel, b_sel;
	logic [7:0]            red_s15, green_s15, blue_s15;
	logic [2:0]            region_s15;

	// whole pipe moves together whenever the output register can take an item
	assign adv      = !vld_s[NS] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_s[NS];
	assign red      = red_s15;
	assign green    = green_s15;
	assign blue     = blue_s15;
	assign region   = region_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-1:1], in_valid};
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= world_x;
			y_s1 <= world_y;
			y_dly_s[2] <= y_s1;
			for (int k = 3; k <= 5; k++) begin
				y_dly_s[k] <= y_dly_s[k-1];
			end
		end
	end

	assign xe       = {{2{x_s1[29]}}, x_s1};
	assign ye       = {{2{y_s1[29]}}, y_s1};
	assign diag_sum = {{3{x_s1[29]}}, x_s1} + {{2{y_s1[29]}}, y_s1, 1'b0};

	// stages 2..5: constant divides and the pixel hash
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::STRIPE_PERIOD)) u_mod96 (
		.clk(clk), .en(adv), .num({{3{x_s1[29]}}, x_s1}), .quot(quot96), .rem(t96)
	);
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::CELL_W)) u_div53 (
		.clk(clk), .en(adv), .num({{3{x_s1[29]}}, x_s1}), .quot(cell_x), .rem(rx)
	);
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::CELL_H)) u_div41 (
		.clk(clk), .en(adv), .num({{3{y_s1[29]}}, y_s1}), .quot(cell_y), .rem(ry)
	);
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::DIAG_MOD)) u_mod23 (
		.clk(clk), .en(adv), .num(diag_sum), .quot(quot23), .rem(r23)
	);
	ptpg_hash u_pix_hash (
		.clk(clk), .en(adv), .key_x(xe), .key_y(ye), .hash(pix_hash)
	);

	// stage 5: per-pixel tests
	assign tri_v = (t96 < 7'(ptpg_pkg::STRIPE_HALF)) ? t96 : 7'(ptpg_pkg::STRIPE_PERIOD) - t96;
	assign ydiff = {{2{y_dly_s[5][29]}}, y_dly_s[5]} - $signed({24'd0, tri_v, 1'b0});

	always_comb begin
		side_st5.stripe = (ydiff > 32'(ptpg_pkg::STRIPE_LO)) &&
			(ydiff < 32'(ptpg_pkg::STRIPE_HI));
		side_st5.speck  = (pix_hash[8:0] == ptpg_pkg::SPECK_VAL);
		side_st5.diag   = (r23 == 5'd0);
		side_st5.shade  = pix_hash[ptpg_pkg::SHADE_W-1:0];
		side_st5.rx     = rx;
		side_st5.ry     = ry;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[6] <= side_st5;
			for (int k = 7; k <= 14; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// stages 6..9: cell hash, stages 10..13: crater jitter
	ptpg_hash u_cell_hash (
		.clk(clk), .en(adv), .key_x(cell_x), .key_y(cell_y), .hash(cell_hash)
	);
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::JIT_X)) u_mod29 (
		.clk(clk), .en(adv), .num({1'b0, cell_hash}), .quot(quot29), .rem(m29)
	);
	ptpg_cdiv #(.DIVISOR(ptpg_pkg::JIT_Y)) u_mod25 (
		.clk(clk), .en(adv),
		.num({{(1+ptpg_pkg::JIT_Y_SHR){1'b0}}, cell_hash[31:ptpg_pkg::JIT_Y_SHR]}),
		.quot(quot25), .rem(m25)
	);

	// stage 13: offset from crater centre, cell origin cancels out
	assign dx  = 8'(side_s[13].rx) - 8'(ptpg_pkg::OFS_X) - 8'(m29);
	assign dy  = 8'(side_s[13].ry) - 8'(ptpg_pkg::OFS_Y) - 8'(m25);
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s14 <= sqx[11:0] + sqy[11:0];
		end
	end

	// stage 14: priority select
	always_comb begin
		if (side_s[14].stripe) begin
			reg_sel = ptpg_pkg::REG_STRIPE;
		end else if (r2_s14 < 12'(ptpg_pkg::CORE_R2)) begin
			reg_sel = ptpg_pkg::REG_CORE;
		end else if (r2_s14 < 12'(ptpg_pkg::RIM_R2)) begin
			reg_sel = ptpg_pkg::REG_RIM;
		end else if (side_s[14].speck) begin
			reg_sel = ptpg_pkg::REG_SPECK;
		end else if (side_s[14].diag) begin
			reg_sel = ptpg_pkg::REG_DIAG;
		end else begin
			reg_sel = ptpg_pkg::REG_BACKGROUND;
		end
	end

	always_comb begin
		case (reg_sel)
			ptpg_pkg::REG_STRIPE: begin
				r_sel = ptpg_pkg::STRIPE_R;
				g_sel = ptpg_pkg::STRIPE_G;
				b_sel = ptpg_pkg::STRIPE_B;
			end
			ptpg_pkg::REG_CORE: begin
				r_sel = ptpg_pkg::CORE_R;
				g_sel = ptpg_pkg::CORE_G;
				b_sel = ptpg_pkg::CORE_B;
			end
			ptpg_pkg::REG_RIM: begin
				r_sel = ptpg_pkg::RIM_R;
				g_sel = ptpg_pkg::RIM_G;
				b_sel = ptpg_pkg::RIM_B;
			end
			ptpg_pkg::REG_SPECK: begin
				r_sel = ptpg_pkg::SPECK_R;
				g_sel = ptpg_pkg::SPECK_G;
				b_sel = ptpg_pkg::SPECK_B;
			end
			ptpg_pkg::REG_DIAG: begin
				r_sel = ptpg_pkg::DIAG_R;
				g_sel = ptpg_pkg::DIAG_G;
				b_sel = ptpg_pkg::DIAG_B;
			end
			default: begin
				r_sel = ptpg_pkg::BG_R + {3'd0, side_s[14].shade};
				g_sel = ptpg_pkg::BG_G + {4'd0, side_s[14].shade[4:1]};
				b_sel = ptpg_pkg::BG_B + {3'd0, side_s[14].shade};
			end
		endcase
	end

	// stage 15: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s15    <= r_sel;
			green_s15  <= g_sel;
			blue_s15   <= b_sel;
			region_s15 <= reg_sel;
		end
	end

	a_advance_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[NS-1] |=> out_valid)
		else $error("item lost between select stage and output register");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s) && $stable(red_s15) && $stable(region_s15))
		else $error("pipeline moved during a stall");

	a_stripe_colour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == ptpg_pkg::REG_STRIPE |->
		red == ptpg_pkg::STRIPE_R && green == ptpg_pkg::STRIPE_G &&
		blue == ptpg_pkg::STRIPE_B)
		else $error("stripe item with wrong colour");

	a_bg_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == ptpg_pkg::REG_BACKGROUND |->
		blue == red + 8'd16)
		else $error("background shade out of step between channels");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> region <= ptpg_pkg::REG_BACKGROUND)
		else $error("region code beyond background");

endmodule
